@@ hdl/tbpm_pkg.sv @@
// Shared types and constants for the typed bracket pair matcher.
// No dependencies; tbpm_front, tbpm_queue, tbpm_back and the top level import this package.
`default_nettype none

package tbpm_pkg;

    localparam int CH_W        = 8;
    localparam int POS_OUT_W   = 16;
    localparam int CNT_W       = 16;
    localparam int RING_W      = 9;
    localparam int SLOT_W      = 8;
    localparam int NUM_TYPES   = 4;
    localparam int TYPE_W      = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int M_TDATA_W   = 96;

    localparam logic [CNT_W-1:0]  COUNT_LIMIT = '1;
    localparam logic [RING_W-1:0] RING_RESET  = 9'd16;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_PUSH = 2'd1,
        OP_POP  = 2'd2
    } op_t;

    typedef struct packed {
        op_t                  op;
        logic [TYPE_W-1:0]    btype;
        logic [POS_OUT_W-1:0] pos;
        logic                 pos_ovf;
        logic                 last;
    } item_t;

endpackage

`default_nettype wire

@@ hdl/tbpm_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module tbpm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hdl/tbpm_front.sv @@
// Front end: accepts characters, assigns positions and classifies brackets.
// Depends on tbpm_pkg.
`default_nettype none

module tbpm_front #(
    parameter int POS_WIDTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] ch
    input  logic                s_tlast,   // last character of the string
    output logic                q_valid,
    input  logic                q_ready,
    output tbpm_pkg::item_t     q_item
);

    import tbpm_pkg::*;

    localparam logic [CH_W-1:0] OPEN_CHARS  [NUM_TYPES] = '{8'h7B, 8'h28, 8'h5B, 8'h3C};
    localparam logic [CH_W-1:0] CLOSE_CHARS [NUM_TYPES] = '{8'h7D, 8'h29, 8'h5D, 8'h3E};

    logic [POS_WIDTH-1:0] pos_reg, pos_next;
    logic                 used_up_reg, used_up_next;
    logic                 accept;

    assign s_tready = q_ready;
    assign q_valid  = s_tvalid;
    assign accept   = s_tvalid & q_ready;

    always_comb
    begin
        q_item.op      = OP_NONE;
        q_item.btype   = '0;
        for (int i = 0; i < NUM_TYPES; i++)
        begin
            if (s_tdata == OPEN_CHARS[i])
            begin
                q_item.op    = OP_PUSH;
                q_item.btype = TYPE_W'(i);
            end
            if (s_tdata == CLOSE_CHARS[i])
            begin
                q_item.op    = OP_POP;
                q_item.btype = TYPE_W'(i);
            end
        end
        q_item.pos     = POS_OUT_W'(pos_reg);
        q_item.pos_ovf = used_up_reg;
        q_item.last    = s_tlast;
    end

    always_comb
    begin
        pos_next     = pos_reg;
        used_up_next = used_up_reg;
        if (accept)
        begin
            if (s_tlast)
            begin
                pos_next     = '0;
                used_up_next = 1'b0;
            end
            else if (!used_up_reg)
            begin
                if (pos_reg == '1)
                begin
                    used_up_next = 1'b1;
                end
                else
                begin
                    pos_next = pos_reg + POS_WIDTH'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            used_up_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            used_up_reg <= used_up_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/tbpm_queue.sv @@
// Short register FIFO carrying classified items from front end to back end.
// Depends on tbpm_pkg.
`default_nettype none

module tbpm_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  tbpm_pkg::item_t wr_item,
    output logic            rd_valid,
    input  logic            rd_ready,
    output tbpm_pkg::item_t rd_item
);

    import tbpm_pkg::*;

    item_t               mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wptr_reg, wptr_next;
    logic [QPTR_W-1:0]   rptr_reg, rptr_next;
    logic [QPTR_W:0]     cnt_reg, cnt_next;
    logic                push, pop;

    assign wr_ready = (cnt_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_item  = mem[rptr_reg];
    assign push     = wr_valid & wr_ready;
    assign pop      = rd_valid & rd_ready;

    always_comb
    begin
        wptr_next = push ? wptr_reg + QPTR_W'(1) : wptr_reg;
        rptr_next = pop ? rptr_reg + QPTR_W'(1) : rptr_reg;
        cnt_next  = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + (QPTR_W+1)'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/tbpm_back.sv @@
// Back end: opener stacks, pair and slot counters, result formatting and output register.
// Depends on tbpm_pkg and tbpm_ram.
`default_nettype none

module tbpm_back #(
    parameter int STACK_DEPTH = 32,
    parameter int RING_MAX    = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               q_valid,
    output logic                               q_ready,
    input  tbpm_pkg::item_t                    q_item,
    input  logic [tbpm_pkg::RING_W-1:0]        ring_size,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tbpm_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tuser,
    output logic                               m_tlast
);

    import tbpm_pkg::*;

    localparam int IDX_W     = $clog2(STACK_DEPTH);
    localparam int HGT_W     = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W    = TYPE_W + IDX_W;
    localparam int RAM_DEPTH = NUM_TYPES << IDX_W;

    // stack and counter state
    logic [HGT_W-1:0]  hgt_reg [NUM_TYPES];
    logic [HGT_W-1:0]  hgt_next [NUM_TYPES];
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [RING_W-1:0] slot_reg, slot_next;
    logic              ovf_reg, ovf_next;

    // result stage waiting for stack read data
    logic              b_valid_reg, b_valid_next;
    logic              b_phase_reg, b_phase_next;
    logic              b_pair_reg, b_last_reg, b_ovf_reg;
    logic [POS_OUT_W-1:0] b_close_reg;
    logic [CNT_W-1:0]  b_num_reg, b_total_reg, b_oldest_reg;
    logic [SLOT_W-1:0] b_slot_reg;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic              m_kind_reg, m_done_reg, m_ovf_reg;
    logic [POS_OUT_W-1:0] m_open_reg, m_close_reg;
    logic [CNT_W-1:0]  m_num_reg, m_total_reg, m_oldest_reg;
    logic [SLOT_W-1:0] m_slot_reg;

    logic [RING_W-1:0] ring_eff;
    logic [HGT_W-1:0]  h, h_dec;
    logic              do_push, do_pop, full, sat, a_go;
    logic [CNT_W-1:0]  total_a, oldest_a;
    logic [RING_W-1:0] slot_a, slot_inc;
    logic              ovf_a;
    logic              out_load, b_emit, b_pair_now, b_final, b_free;
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [POS_OUT_W-1:0] ram_rdata;

    tbpm_ram #(
        .WIDTH (POS_OUT_W),
        .DEPTH (RAM_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (q_item.pos),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (ring_size == '0)
        begin
            ring_eff = RING_W'(1);
        end
        else if (int'(ring_size) > RING_MAX)
        begin
            ring_eff = RING_W'(RING_MAX);
        end
        else
        begin
            ring_eff = ring_size;
        end
    end

    // handshake between stages
    assign out_load   = !m_valid_reg || m_tready;
    assign b_emit     = b_valid_reg && out_load;
    assign b_pair_now = b_pair_reg && !b_phase_reg;
    assign b_final    = b_pair_now ? !b_last_reg : 1'b1;
    assign b_free     = !b_valid_reg || (b_emit && b_final);
    assign q_ready    = b_free;
    assign a_go       = q_valid && b_free;

    // execute stage
    always_comb
    begin
        h       = hgt_reg[q_item.btype];
        h_dec   = h - HGT_W'(1);
        do_push = (q_item.op == OP_PUSH) && (int'(h) < STACK_DEPTH);
        full    = (q_item.op == OP_PUSH) && !(int'(h) < STACK_DEPTH);
        do_pop  = (q_item.op == OP_POP) && (h != '0);
        sat     = do_pop && (cnt_reg == COUNT_LIMIT);
        total_a = (do_pop && !sat) ? cnt_reg + CNT_W'(1) : cnt_reg;
        oldest_a = (total_a > CNT_W'(ring_eff)) ? total_a - CNT_W'(ring_eff) : '0;
        slot_a  = (slot_reg >= ring_eff) ? '0 : slot_reg;
        slot_inc = slot_a + RING_W'(1);
        ovf_a   = ovf_reg | q_item.pos_ovf | full | sat;

        ram_we    = a_go && do_push;
        ram_waddr = {q_item.btype, h[IDX_W-1:0]};
        ram_re    = a_go && do_pop;
        ram_raddr = {q_item.btype, h_dec[IDX_W-1:0]};

        hgt_next  = hgt_reg;
        cnt_next  = cnt_reg;
        slot_next = slot_reg;
        ovf_next  = ovf_reg;
        if (a_go)
        begin
            if (q_item.last)
            begin
                for (int i = 0; i < NUM_TYPES; i++)
                begin
                    hgt_next[i] = '0;
                end
                cnt_next  = '0;
                slot_next = '0;
                ovf_next  = 1'b0;
            end
            else
            begin
                if (do_push)
                begin
                    hgt_next[q_item.btype] = h + HGT_W'(1);
                end
                if (do_pop)
                begin
                    hgt_next[q_item.btype] = h_dec;
                    slot_next = (slot_inc >= ring_eff) ? '0 : slot_inc;
                end
                cnt_next = total_a;
                ovf_next = ovf_a;
            end
        end
    end

    always_comb
    begin
        b_valid_next = b_valid_reg;
        b_phase_next = b_phase_reg;
        if (a_go)
        begin
            b_valid_next = do_pop || q_item.last;
            b_phase_next = 1'b0;
        end
        else if (b_emit)
        begin
            if (b_final)
            begin
                b_valid_next = 1'b0;
            end
            else
            begin
                b_phase_next = 1'b1;
            end
        end
        m_valid_next = out_load ? b_valid_reg : m_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TYPES; i++)
            begin
                hgt_reg[i] <= '0;
            end
            cnt_reg     <= '0;
            slot_reg    <= '0;
            ovf_reg     <= 1'b0;
            b_valid_reg <= 1'b0;
            b_phase_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            hgt_reg     <= hgt_next;
            cnt_reg     <= cnt_next;
            slot_reg    <= slot_next;
            ovf_reg     <= ovf_next;
            b_valid_reg <= b_valid_next;
            b_phase_reg <= b_phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_go)
        begin
            b_pair_reg   <= do_pop;
            b_last_reg   <= q_item.last;
            b_close_reg  <= q_item.pos;
            b_num_reg    <= cnt_reg;
            b_slot_reg   <= SLOT_W'(slot_a);
            b_total_reg  <= total_a;
            b_oldest_reg <= oldest_a;
            b_ovf_reg    <= ovf_a;
        end
        if (b_emit)
        begin
            m_kind_reg   <= !b_pair_now;
            m_open_reg   <= b_pair_now ? ram_rdata : '0;
            m_close_reg  <= b_pair_now ? b_close_reg : '0;
            m_num_reg    <= b_pair_now ? b_num_reg : '0;
            m_slot_reg   <= b_pair_now ? b_slot_reg : '0;
            m_total_reg  <= b_pair_now ? '0 : b_total_reg;
            m_oldest_reg <= b_pair_now ? '0 : b_oldest_reg;
            m_ovf_reg    <= b_ovf_reg;
            m_done_reg   <= b_final;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_done_reg;
    assign m_tdata  = {7'b0, m_ovf_reg, m_oldest_reg, m_total_reg, m_slot_reg,
                       m_num_reg, m_close_reg, m_open_reg};

endmodule

`default_nettype wire

@@ hdl/typed_bracket_pair_matcher.sv @@
// Top level of the typed bracket pair matcher: ring size register, front end, queue, back end.
// Depends on tbpm_pkg, tbpm_front, tbpm_queue, tbpm_back and tbpm_ram.
//
//   Channel  Dir  Handshake           Payload
//   s_       in   s_tvalid/s_tready   s_tdata = ch, s_tlast = last
//   m_       out  m_tvalid/m_tready   m_tuser = kind, m_tdata = pair/summary, m_tlast = done_res
//   cfg_     in   cfg_valid/cfg_ready cfg_data = ring_size
//
// One character per cycle while the output accepts; results pass the result and output registers.
// A last character that closes a pair gives two results, the pair and then the summary.
// The output rate is set by the single output register and the stack RAM with its single read port.
// Reset clears stack heights and counters at once; stack RAM contents are not cleared.
// A four-entry queue lets the input keep flowing for four items while the output stalls.
`default_nettype none

module typed_bracket_pair_matcher #(
    parameter int STACK_DEPTH = 32,
    parameter int POS_WIDTH   = 16,
    parameter int RING_MAX    = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,   // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // [15:0] open_pos, [31:16] close_pos, [47:32] pair_number,
                                   // [55:48] slot, [71:56] total_pairs, [87:72] oldest_index,
                                   // [88] overflow, [95:89] zero
    output logic        m_tuser,   // [0] kind
    output logic        m_tlast,   // done_res
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data   // [8:0] ring_size
);

    import tbpm_pkg::*;

    logic [RING_W-1:0] ring_reg, ring_next;
    logic              fq_valid, fq_ready, qb_valid, qb_ready;
    item_t             fq_item, qb_item;

    assign cfg_ready = 1'b1;
    assign ring_next = (cfg_valid && cfg_ready) ? cfg_data : ring_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_reg <= RING_RESET;
        end
        else
        begin
            ring_reg <= ring_next;
        end
    end

    tbpm_front #(
        .POS_WIDTH (POS_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_valid  (fq_valid),
        .q_ready  (fq_ready),
        .q_item   (fq_item)
    );

    tbpm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_item  (fq_item),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_item  (qb_item)
    );

    tbpm_back #(
        .STACK_DEPTH (STACK_DEPTH),
        .RING_MAX    (RING_MAX)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (qb_valid),
        .q_ready   (qb_ready),
        .q_item    (qb_item),
        .ring_size (ring_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
